/* rtl/source_text_tokenizer_top_assert.svh */
// Assertion macros for the source text tokenizer.
`ifndef SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH
`ifndef SYNTH
`define STT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");
`define STT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");
`else
`define STT_ASSERT_NOW(label, ante, cons)
`define STT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/stt_pkg.sv */
// Shared types, constants and helper functions for the source text tokenizer.
package stt_pkg;

	localparam int MAX_TOKEN_LENGTH = 255;
	localparam logic [7:0] LEN_LIMIT =
		(MAX_TOKEN_LENGTH > 255) ? 8'd255 : 8'(MAX_TOKEN_LENGTH);

	localparam int NUM_KW = 12;
	localparam int KW_MAX_LEN = 6;
	localparam logic [NUM_KW-1:0] ALL_KW = '1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef logic [4:0] kind_t;
	typedef logic [7:0] len_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_NUMBER  = 3'd2,
		MODE_STRING  = 3'd3,
		MODE_COMMENT = 3'd4,
		MODE_ERROR   = 3'd5
	} lex_mode_t;

	localparam kind_t KIND_EOF     = 5'd0;
	localparam kind_t KIND_TYPE    = 5'd1;
	localparam kind_t KIND_IDENT   = 5'd2;
	localparam kind_t KIND_NUMBER  = 5'd3;
	localparam kind_t KIND_DOT     = 5'd4;
	localparam kind_t KIND_EQ      = 5'd5;
	localparam kind_t KIND_COMMA   = 5'd6;
	localparam kind_t KIND_PLUS    = 5'd7;
	localparam kind_t KIND_MINUS   = 5'd8;
	localparam kind_t KIND_SLASH   = 5'd9;
	localparam kind_t KIND_STAR    = 5'd10;
	localparam kind_t KIND_LT      = 5'd11;
	localparam kind_t KIND_GT      = 5'd12;
	localparam kind_t KIND_LBRACE  = 5'd13;
	localparam kind_t KIND_RBRACE  = 5'd14;
	localparam kind_t KIND_LPAREN  = 5'd15;
	localparam kind_t KIND_RPAREN  = 5'd16;
	localparam kind_t KIND_STRING  = 5'd17;
	localparam kind_t KIND_UNKNOWN = 5'd18;
	localparam kind_t KIND_UNTERM  = 5'd19;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOT    = 8'h2e;

	localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"f", "l", "o", "a", "t", 8'h00},
		'{"s", "t", "r", "i", "n", "g"},
		'{"a", "r", "r", "a", "y", 8'h00},
		'{"j", "s", "o", "n", 8'h00, 8'h00},
		'{"r", "e", "g", "e", "x", 8'h00},
		'{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"h", "e", "x", 8'h00, 8'h00, 8'h00},
		'{"a", "u", "t", "o", 8'h00, 8'h00},
		'{"a", "n", "y", 8'h00, 8'h00, 8'h00},
		'{"n", "u", "l", "l", 8'h00, 8'h00},
		'{"n", "o", "n", "e", 8'h00, 8'h00}
	};
	localparam len_t KW_LEN [NUM_KW] = '{
		8'd3, 8'd5, 8'd6, 8'd5, 8'd4, 8'd5, 8'd2, 8'd3, 8'd4, 8'd3, 8'd4, 8'd4
	};

	typedef struct packed {
		logic  two;
		kind_t kind0;
		len_t  len0;
		kind_t kind1;
		len_t  len1;
	} entry_t;

	typedef struct packed {
		logic push;
		logic in_error;
	} front_stat_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic len_t len_inc(input len_t n);
		return (n < LEN_LIMIT) ? n + 8'd1 : n;
	endfunction

	function automatic kind_t op_kind(input logic [7:0] c);
		kind_t k;
		unique case (c)
			"=":     k = KIND_EQ;
			",":     k = KIND_COMMA;
			"+":     k = KIND_PLUS;
			"-":     k = KIND_MINUS;
			"/":     k = KIND_SLASH;
			"*":     k = KIND_STAR;
			"<":     k = KIND_LT;
			">":     k = KIND_GT;
			"{":     k = KIND_LBRACE;
			"}":     k = KIND_RBRACE;
			"(":     k = KIND_LPAREN;
			")":     k = KIND_RPAREN;
			default: k = KIND_EOF;
		endcase
		return k;
	endfunction

	// Keyword characters past a keyword's end read as NUL, which never matches here.
	function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] cand,
			input len_t pos, input logic [7:0] c);
		logic [NUM_KW-1:0] r;
		r = cand;
		for (int i = 0; i < NUM_KW; i++) begin
			if (!(pos < KW_LEN[i] && KW_TEXT[i][pos[2:0]] == c))
				r[i] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic kw_hit(input logic [NUM_KW-1:0] cand, input len_t n);
		logic h;
		h = 1'b0;
		for (int i = 0; i < NUM_KW; i++) begin
			if (cand[i] && KW_LEN[i] == n)
				h = 1'b1;
		end
		return h;
	endfunction

endpackage

/* rtl/source_text_tokenizer_top.sv */
// Each accepted byte's token entry is written into the token queue; the output presents the queue head.
// One byte is accepted per cycle while the four-entry token queue has room.
// A byte that causes two tokens is given out as two transactions; the output
// side thus sets the sustained rate for such input.
// Reset clears the lexer to idle mode and empties the queue at once.
`include "source_text_tokenizer_top_assert.svh"
module source_text_tokenizer_top import stt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] token_kind,
	output logic [7:0] token_length,
	output logic       last_of_run
);

	entry_t      push_data, head;
	front_stat_t fstat;
	logic        q_full, q_empty, pop, accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	stt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_in   (char_in),
		.push_data (push_data),
		.stat      (fstat)
	);

	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fstat.push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	stt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	`STT_ASSERT_NEXT(a_push_fills, fstat.push, !q_empty)
	`STT_ASSERT_NEXT(a_error_sticky, fstat.in_error, fstat.in_error)
	`STT_ASSERT_NOW(a_error_silent, fstat.in_error, !fstat.push)

endmodule

/* rtl/stt_front.sv */
// Front end: accepts source bytes, tracks lexer state and builds token entries.
module stt_front import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  char_in,
	output entry_t      push_data,
	output front_stat_t stat
);

	lex_mode_t         mode_q, mode_n;
	logic              quote_q, quote_n;
	logic [NUM_KW-1:0] cand_q, cand_n;
	len_t              len_q, len_n;
	logic              dig_q, dig_n;

	lex_mode_t         sb_mode;
	logic              sb_quote, sb_dig, sb_emit;
	logic [NUM_KW-1:0] sb_cand;
	len_t              sb_len_n, sb_len;
	kind_t             sb_kind, op_k;

	logic  r0_v, r1_v;
	kind_t r0_kind, r1_kind;
	len_t  r0_len, r1_len;

	assign op_k = op_kind(char_in);

	// byte handling from idle
	always_comb begin
		sb_mode  = MODE_IDLE;
		sb_quote = quote_q;
		sb_dig   = dig_q;
		sb_cand  = cand_q;
		sb_len_n = len_q;
		sb_emit  = 1'b0;
		sb_kind  = KIND_EOF;
		sb_len   = '0;
		if (is_space(char_in)) begin
			sb_mode = MODE_IDLE;
		end else if (char_in == CH_NUL) begin
			sb_emit = 1'b1;
		end else if (is_alpha(char_in)) begin
			sb_mode  = MODE_IDENT;
			sb_cand  = kw_filter(ALL_KW, '0, char_in);
			sb_len_n = len_inc('0);
		end else if (is_digit(char_in) || char_in == CH_DOT) begin
			sb_mode  = MODE_NUMBER;
			sb_dig   = is_digit(char_in);
			sb_len_n = len_inc('0);
		end else if (op_k != KIND_EOF) begin
			sb_emit = 1'b1;
			sb_kind = op_k;
			sb_len  = 8'd1;
		end else if (char_in == CH_SQUOTE || char_in == CH_DQUOTE) begin
			sb_mode  = MODE_STRING;
			sb_quote = (char_in == CH_DQUOTE);
			sb_len_n = '0;
		end else if (char_in == CH_HASH) begin
			sb_mode = MODE_COMMENT;
		end else begin
			sb_emit = 1'b1;
			sb_kind = KIND_UNKNOWN;
			sb_len  = 8'd1;
			sb_mode = MODE_ERROR;
		end
	end

	// next lexer state
	always_comb begin
		mode_n  = mode_q;
		quote_n = quote_q;
		cand_n  = cand_q;
		len_n   = len_q;
		dig_n   = dig_q;
		unique case (mode_q)
			MODE_ERROR: begin
				mode_n = MODE_ERROR;
			end
			MODE_IDENT: begin
				if (is_alpha(char_in) || is_digit(char_in)) begin
					cand_n = kw_filter(cand_q, len_q, char_in);
					len_n  = len_inc(len_q);
				end else begin
					mode_n  = sb_mode;
					quote_n = sb_quote;
					cand_n  = sb_cand;
					len_n   = sb_len_n;
					dig_n   = sb_dig;
				end
			end
			MODE_NUMBER: begin
				if (is_digit(char_in) || char_in == CH_DOT) begin
					if (is_digit(char_in))
						dig_n = 1'b1;
					len_n = len_inc(len_q);
				end else begin
					mode_n  = sb_mode;
					quote_n = sb_quote;
					cand_n  = sb_cand;
					len_n   = sb_len_n;
					dig_n   = sb_dig;
				end
			end
			MODE_STRING: begin
				if (char_in == (quote_q ? CH_DQUOTE : CH_SQUOTE))
					mode_n = MODE_IDLE;
				else if (char_in == CH_NUL)
					mode_n = MODE_ERROR;
				else
					len_n = len_inc(len_q);
			end
			MODE_COMMENT: begin
				if (char_in == CH_NUL || char_in == CH_LF || char_in == CH_CR)
					mode_n = MODE_IDLE;
			end
			default: begin
				mode_n  = sb_mode;
				quote_n = sb_quote;
				cand_n  = sb_cand;
				len_n   = sb_len_n;
				dig_n   = sb_dig;
			end
		endcase
	end

	// token entry for this byte
	always_comb begin
		r0_v    = 1'b0;
		r0_kind = KIND_EOF;
		r0_len  = '0;
		r1_v    = 1'b0;
		r1_kind = KIND_EOF;
		r1_len  = '0;
		unique case (mode_q)
			MODE_ERROR: begin
				r0_v = 1'b0;
			end
			MODE_IDENT: begin
				if (!(is_alpha(char_in) || is_digit(char_in))) begin
					r0_v    = 1'b1;
					r0_kind = kw_hit(cand_q, len_q) ? KIND_TYPE : KIND_IDENT;
					r0_len  = len_q;
					r1_v    = sb_emit;
					r1_kind = sb_kind;
					r1_len  = sb_len;
				end
			end
			MODE_NUMBER: begin
				if (!(is_digit(char_in) || char_in == CH_DOT)) begin
					r0_v    = 1'b1;
					r0_kind = (!dig_q && len_q == 8'd1) ? KIND_DOT : KIND_NUMBER;
					r0_len  = len_q;
					r1_v    = sb_emit;
					r1_kind = sb_kind;
					r1_len  = sb_len;
				end
			end
			MODE_STRING: begin
				if (char_in == (quote_q ? CH_DQUOTE : CH_SQUOTE)) begin
					r0_v    = 1'b1;
					r0_kind = KIND_STRING;
					r0_len  = len_q;
				end else if (char_in == CH_NUL) begin
					r0_v    = 1'b1;
					r0_kind = KIND_UNTERM;
					r0_len  = len_q;
				end
			end
			MODE_COMMENT: begin
				if (char_in == CH_NUL)
					r0_v = 1'b1;
			end
			default: begin
				r0_v    = sb_emit;
				r0_kind = sb_kind;
				r0_len  = sb_len;
			end
		endcase
	end

	assign push_data.two   = r1_v;
	assign push_data.kind0 = r0_kind;
	assign push_data.len0  = r0_len;
	assign push_data.kind1 = r1_kind;
	assign push_data.len1  = r1_len;

	assign stat.push     = accept && r0_v;
	assign stat.in_error = (mode_q == MODE_ERROR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			quote_q <= 1'b0;
			cand_q  <= ALL_KW;
			len_q   <= '0;
			dig_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_n;
			quote_q <= quote_n;
			cand_q  <= cand_n;
			len_q   <= len_n;
			dig_q   <= dig_n;
		end
	end

endmodule

/* rtl/stt_queue.sv */
// Short queue of token entries between the front and back ends.
module stt_queue import stt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/stt_back.sv */
// Back end: serializes each queued entry into one or two result transactions.
module stt_back import stt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t head,
	input  logic   empty,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output kind_t  token_kind,
	output len_t   token_length,
	output logic   last_of_run
);

	logic phase_q;

	assign out_valid    = !empty;
	assign token_kind   = phase_q ? head.kind1 : head.kind0;
	assign token_length = phase_q ? head.len1 : head.len0;
	assign last_of_run  = !head.two || phase_q;
	assign pop          = out_valid && out_ready && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= 1'b0;
		else if (out_valid && out_ready)
			phase_q <= !last_of_run;
	end

endmodule

/* tb/sv/tb_source_text_tokenizer_top.sv */
// Self-checking testbench for the source text tokenizer: directed table, random token streams.
`timescale 1ns / 100ps
module tb_source_text_tokenizer_top import stt_pkg::*; ();

	localparam int ITEMS       = 1800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DIR_N       = 27;

	typedef struct packed {
		kind_t kind;
		len_t  len;
		logic  last;
	} tok_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       typed;
		logic [1:0] cnt;
		kind_t      k0;
		len_t       l0;
		kind_t      k1;
		len_t       l1;
	} row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_t;

	localparam row_t DIR_ROWS [DIR_N] = '{
		'{"i",       1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{"n",       1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{"t",       1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{"=",       1'b1, 2'd2, KIND_TYPE,    8'd3, KIND_EQ,     8'd1},
		'{",",       1'b1, 2'd1, KIND_COMMA,   8'd1, KIND_EOF,    8'd0},
		'{"+",       1'b1, 2'd1, KIND_PLUS,    8'd1, KIND_EOF,    8'd0},
		'{"-",       1'b1, 2'd1, KIND_MINUS,   8'd1, KIND_EOF,    8'd0},
		'{"/",       1'b1, 2'd1, KIND_SLASH,   8'd1, KIND_EOF,    8'd0},
		'{"*",       1'b1, 2'd1, KIND_STAR,    8'd1, KIND_EOF,    8'd0},
		'{"<",       1'b1, 2'd1, KIND_LT,      8'd1, KIND_EOF,    8'd0},
		'{">",       1'b1, 2'd1, KIND_GT,      8'd1, KIND_EOF,    8'd0},
		'{"{",       1'b1, 2'd1, KIND_LBRACE,  8'd1, KIND_EOF,    8'd0},
		'{"}",       1'b1, 2'd1, KIND_RBRACE,  8'd1, KIND_EOF,    8'd0},
		'{"(",       1'b1, 2'd1, KIND_LPAREN,  8'd1, KIND_EOF,    8'd0},
		'{CH_DOT,    1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{")",       1'b1, 2'd2, KIND_DOT,     8'd1, KIND_RPAREN, 8'd1},
		'{CH_DQUOTE, 1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{8'hff,     1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{CH_DQUOTE, 1'b1, 2'd1, KIND_STRING,  8'd1, KIND_EOF,    8'd0},
		'{CH_HASH,   1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{8'h80,     1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{CH_NUL,    1'b1, 2'd1, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{"7",       1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{CH_NUL,    1'b1, 2'd2, KIND_NUMBER,  8'd1, KIND_EOF,    8'd0},
		'{CH_HASH,   1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{CH_CR,     1'b0, 2'd0, KIND_EOF,     8'd0, KIND_EOF,    8'd0},
		'{CH_NUL,    1'b1, 2'd1, KIND_EOF,     8'd0, KIND_EOF,    8'd0}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] char_in;
	logic       out_valid;
	logic       out_ready;
	logic [4:0] token_kind;
	logic [7:0] token_length;
	logic       last_of_run;

	string      kw_words [NUM_KW] = '{"int", "float", "string", "array", "json", "regex",
		"fn", "hex", "auto", "any", "null", "none"};
	logic [7:0] punct_set [12] = '{"=", ",", "+", "-", "/", "*", "<", ">", "{", "}", "(", ")"};

	lex_mode_t         lx_mode;
	logic              lx_dq;
	logic [NUM_KW-1:0] lx_kw;
	len_t              lx_len;
	logic              lx_digit;
	tok_t              pend [2];
	int                pend_n;

	tok_t      tok_expect [$];
	tok_t      want;
	row_t      given;
	int        bytes_sent = 0;
	int        tok_seen   = 0;
	int        two_cnt    = 0;
	int        sat_cnt    = 0;
	int        bad_cnt    = 0;
	int        cyc        = 0;
	int        burst_left = 0;
	logic      no_gaps    = 1'b0;
	logic      hold_req   = 1'b0;
	logic      hold_done  = 1'b0;
	int        hold_left  = 0;
	int        rx_left    = 0;
	rx_style_t rx_style   = RX_OPEN;
	string     tail_how;

	source_text_tokenizer_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_in      (char_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;

	initial begin
		wait (cyc >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d tokens outstanding", cyc, tok_expect.size());
		$display("tb_source_text_tokenizer_top NOT OK");
		$finish;
	end

	function automatic logic blank_ch(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic letter_ch(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic digit_ch(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] c);
		case (c)
			"=":     return KIND_EQ;
			",":     return KIND_COMMA;
			"+":     return KIND_PLUS;
			"-":     return KIND_MINUS;
			"/":     return KIND_SLASH;
			"*":     return KIND_STAR;
			"<":     return KIND_LT;
			">":     return KIND_GT;
			"{":     return KIND_LBRACE;
			"}":     return KIND_RBRACE;
			"(":     return KIND_LPAREN;
			")":     return KIND_RPAREN;
			default: return KIND_EOF;
		endcase
	endfunction

	function automatic len_t len_up(input len_t n);
		return (n == LEN_LIMIT) ? n : n + 8'd1;
	endfunction

	function automatic logic kw_match();
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_KW; i++)
			if (lx_kw[i] && kw_words[i].len() == int'(lx_len))
				hit = 1'b1;
		return hit;
	endfunction

	task automatic kw_narrow(input logic [7:0] c);
		for (int i = 0; i < NUM_KW; i++)
			if (int'(lx_len) >= kw_words[i].len() || 8'(kw_words[i][lx_len]) != c)
				lx_kw[i] = 1'b0;
	endtask

	task automatic emit_tok(input kind_t k, input len_t n);
		if (pend_n < 2) begin
			pend[pend_n] = tok_t'{kind: k, len: n, last: 1'b0};
			pend_n++;
		end
	endtask

	// byte as seen from idle
	task automatic lex_fresh(input logic [7:0] c);
		kind_t k;
		k = punct_kind(c);
		lx_mode = MODE_IDLE;
		if (c == CH_NUL)
			emit_tok(KIND_EOF, 8'd0);
		else if (letter_ch(c)) begin
			lx_mode = MODE_IDENT;
			lx_kw = '1;
			lx_len = 8'd0;
			kw_narrow(c);
			lx_len = len_up(8'd0);
		end else if (digit_ch(c) || c == CH_DOT) begin
			lx_mode = MODE_NUMBER;
			lx_digit = digit_ch(c);
			lx_len = len_up(8'd0);
		end else if (k != KIND_EOF)
			emit_tok(k, 8'd1);
		else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
			lx_mode = MODE_STRING;
			lx_dq = (c == CH_DQUOTE);
			lx_len = 8'd0;
		end else if (c == CH_HASH)
			lx_mode = MODE_COMMENT;
		else if (!blank_ch(c)) begin
			emit_tok(KIND_UNKNOWN, 8'd1);
			lx_mode = MODE_ERROR;
		end
	endtask

	task automatic lex_step(input logic [7:0] c);
		pend_n = 0;
		case (lx_mode)
			MODE_ERROR: ;
			MODE_IDENT:
				if (letter_ch(c) || digit_ch(c)) begin
					kw_narrow(c);
					lx_len = len_up(lx_len);
				end else begin
					emit_tok(kw_match() ? KIND_TYPE : KIND_IDENT, lx_len);
					lex_fresh(c);
				end
			MODE_NUMBER:
				if (digit_ch(c) || c == CH_DOT) begin
					if (digit_ch(c))
						lx_digit = 1'b1;
					lx_len = len_up(lx_len);
				end else begin
					emit_tok((!lx_digit && lx_len == 8'd1) ? KIND_DOT : KIND_NUMBER, lx_len);
					lex_fresh(c);
				end
			MODE_STRING:
				if (c == (lx_dq ? CH_DQUOTE : CH_SQUOTE)) begin
					emit_tok(KIND_STRING, lx_len);
					lx_mode = MODE_IDLE;
				end else if (c == CH_NUL) begin
					emit_tok(KIND_UNTERM, lx_len);
					lx_mode = MODE_ERROR;
				end else
					lx_len = len_up(lx_len);
			MODE_COMMENT:
				if (c == CH_NUL) begin
					emit_tok(KIND_EOF, 8'd0);
					lx_mode = MODE_IDLE;
				end else if (c == CH_LF || c == CH_CR)
					lx_mode = MODE_IDLE;
			default: lex_fresh(c);
		endcase
		if (pend_n > 0)
			pend[pend_n - 1].last = 1'b1;
	endtask

	task automatic send_byte(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		char_in <= c;
		do @(posedge clk); while (!in_ready);
		lex_step(c);
		bytes_sent++;
		if (given.typed) begin
			if (given.cnt != 2'd0)
				tok_expect.push_back(tok_t'{kind: given.k0, len: given.l0,
					last: given.cnt == 2'd1});
			if (given.cnt == 2'd2)
				tok_expect.push_back(tok_t'{kind: given.k1, len: given.l1, last: 1'b1});
		end else
			for (int i = 0; i < pend_n; i++)
				tok_expect.push_back(pend[i]);
		if (pend_n == 2)
			two_cnt++;
		for (int i = 0; i < pend_n; i++)
			if (pend[i].len == LEN_LIMIT)
				sat_cnt++;
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] b;
		b = 8'($urandom_range(0, 25));
		return ($urandom_range(0, 3) == 0) ? 8'("A") + b : 8'("a") + b;
	endfunction

	function automatic logic [7:0] rand_alnum();
		return ($urandom_range(0, 3) == 0) ? 8'("0") + 8'($urandom_range(0, 9)) : rand_letter();
	endfunction

	function automatic logic [7:0] rand_blank();
		logic [7:0] b;
		b = 8'($urandom_range(9, 14));
		return (b == 8'd14) ? 8'd32 : b;
	endfunction

	// well-formed tokens with random content; never opens the error state
	task automatic send_token();
		int         pick;
		int         n;
		int         k;
		logic [7:0] q;
		logic [7:0] b;
		string      w;
		pick = $urandom_range(0, 99);
		n = ($urandom_range(0, 149) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 6);
		if (pick < 22) begin
			send_byte(rand_letter());
			for (int i = 1; i < n; i++)
				send_byte(rand_alnum());
		end else if (pick < 34) begin
			// keyword, truncated, extended or capitalized
			w = kw_words[$urandom_range(0, NUM_KW - 1)];
			k = $urandom_range(0, 3);
			if (k == 1)
				w = w.substr(0, w.len() - 2);
			for (int i = 0; i < w.len(); i++)
				send_byte((k == 3 && i == 0) ? 8'(w[i]) - 8'd32 : 8'(w[i]));
			if (k == 2)
				send_byte(rand_alnum());
		end else if (pick < 48) begin
			for (int i = 0; i < n; i++)
				send_byte(($urandom_range(0, 3) == 0) ? CH_DOT :
					8'("0") + 8'($urandom_range(0, 9)));
		end else if (pick < 64)
			send_byte(punct_set[$urandom_range(0, 11)]);
		else if (pick < 75) begin
			q = ($urandom_range(0, 1) == 0) ? CH_DQUOTE : CH_SQUOTE;
			send_byte(q);
			for (int i = 1; i < n; i++) begin
				do b = 8'($urandom_range(1, 255)); while (b == q);
				send_byte(b);
			end
			send_byte(q);
		end else if (pick < 83) begin
			send_byte(CH_HASH);
			repeat ($urandom_range(0, 8)) begin
				do b = 8'($urandom_range(1, 255)); while (b == CH_LF || b == CH_CR);
				send_byte(b);
			end
			k = $urandom_range(0, 2);
			send_byte((k == 0) ? CH_LF : (k == 1) ? CH_CR : CH_NUL);
		end else if (pick < 89)
			send_byte(CH_NUL);
		else begin
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(0, 4))
					0:       b = rand_blank();
					1:       b = punct_set[$urandom_range(0, 11)];
					2:       b = rand_alnum();
					3:       b = CH_DOT;
					default: b = CH_NUL;
				endcase
				send_byte(b);
			end
		end
		if ($urandom_range(0, 2) != 0)
			send_byte(rand_blank());
	endtask

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'(2'($urandom_range(0, 3)));
			rx_left = $urandom_range(20, 300);
		end
		rx_left--;
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			case (rx_style)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= (rx_left % 4 == 0);
				default:   out_ready <= ($urandom_range(0, 7) != 0);
			endcase
	end

	task automatic flag_bad(input string what, input tok_t exp_tok);
		bad_cnt++;
		if (bad_cnt <= 10)
			$display("%0t %s: expected kind %0d len %0d last %0d, got kind %0d len %0d last %0d",
				$realtime, what, exp_tok.kind, exp_tok.len, exp_tok.last,
				token_kind, token_length, last_of_run);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (tok_expect.size() == 0)
				flag_bad("token with none expected", '0);
			else begin
				want = tok_expect.pop_front();
				tok_seen++;
				if (token_kind !== want.kind || token_length !== want.len ||
						last_of_run !== want.last)
					flag_bad("token mismatch", want);
			end
		end
	end

	initial begin
		logic [7:0] b;
		int         start;
		logic       pressed;
		pressed = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		char_in <= 8'd0;
		out_ready <= 1'b0;
		given = '0;
		lx_mode = MODE_IDLE;
		lx_dq = 1'b0;
		lx_kw = '1;
		lx_len = 8'd0;
		lx_digit = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_N; r++) begin
			given = DIR_ROWS[r];
			send_byte(given.ch);
		end
		given.typed = 1'b0;

		start = bytes_sent;
		while (bytes_sent - start < ITEMS) begin
			send_token();
			if (!pressed && bytes_sent - start > 600) begin
				// receiver holds off while the sender keeps pushing operators
				pressed = 1'b1;
				hold_req <= 1'b1;
				no_gaps = 1'b1;
				repeat (40)
					send_byte(punct_set[$urandom_range(0, 11)]);
				no_gaps = 1'b0;
			end
		end

		// sticky error entry, then bytes that must be ignored
		send_byte(8'd32);
		if ($urandom_range(0, 1) == 0) begin
			do b = 8'($urandom_range(1, 255));
			while (blank_ch(b) || letter_ch(b) || digit_ch(b) || b == CH_DOT ||
				punct_kind(b) != KIND_EOF || b == CH_SQUOTE || b == CH_DQUOTE ||
				b == CH_HASH);
			given = '{b, 1'b1, 2'd1, KIND_UNKNOWN, 8'd1, KIND_EOF, 8'd0};
			send_byte(b);
			tail_how = "unknown byte";
		end else begin
			given.typed = 1'b0;
			send_byte(CH_SQUOTE);
			repeat (3) send_byte("z");
			given = '{CH_NUL, 1'b1, 2'd1, KIND_UNTERM, 8'd3, KIND_EOF, 8'd0};
			send_byte(CH_NUL);
			tail_how = "unterminated string";
		end
		given = '{8'd0, 1'b1, 2'd0, KIND_EOF, 8'd0, KIND_EOF, 8'd0};
		repeat (30) send_byte(8'($urandom_range(0, 255)));
		in_valid <= 1'b0;

		while (tok_expect.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d bytes, %0d tokens compared, %0d bytes giving two tokens",
			bytes_sent, tok_seen, two_cnt);
		$display("%0d saturated lengths, error state entered by %s, %0d mismatches",
			sat_cnt, tail_how, bad_cnt);
		if (bad_cnt == 0)
			$display("tb_source_text_tokenizer_top OK");
		else
			$display("tb_source_text_tokenizer_top NOT OK");
		$finish;
	end

endmodule
